/* design/pberc_pkg.sv */
// Package for the packet bit error rate checker.
// Holds the transaction structs and the fixed constants of the expected pattern.
// It has no dependencies. The compare unit and the top level import it.
package pberc_pkg;

    // Field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SEED_W  = 8;
    localparam int unsigned PHASE_W = 7;
    localparam int unsigned ERR_W   = 6;
    localparam int unsigned TOTAL_W = 48;

    // Pattern constants
    localparam logic [WORD_W-1:0]  PATTERN_STEP   = 32'd77777;
    localparam logic [PHASE_W-1:0] PATTERN_LAST   = 7'd79;
    localparam logic [PHASE_W-1:0] SEQ_PERIOD     = 7'd20;
    localparam logic [PHASE_W-1:0] SEQ_SLOT_1     = 7'd20;
    localparam logic [PHASE_W-1:0] SEQ_SLOT_2     = 7'd40;
    localparam logic [PHASE_W-1:0] SEQ_SLOT_3     = 7'd60;
    localparam logic [PHASE_W-1:0] PHASE_AFTER_SEQ = 7'd1;
    localparam int unsigned        SEED_SHIFT     = 24;
    localparam logic [ERR_W-1:0]   WORD_BITS      = 6'd32;

    // Input transaction
    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] rx_word;
        logic              first_word;
    } pberc_in_t;

    // Result transaction
    typedef struct packed {
        logic [ERR_W-1:0]   word_bit_errors;
        logic               sequence_break;
        logic [TOTAL_W-1:0] wrong_bits_total;
        logic [TOTAL_W-1:0] right_bits_total;
    } pberc_out_t;

    // Word comparison request and answer between top level and compare unit
    typedef struct packed {
        logic [WORD_W-1:0]  rx_word;
        logic [WORD_W-1:0]  seq_word;
        logic [SEED_W-1:0]  seed;
        logic [PHASE_W-1:0] phase;
    } pberc_cmp_req_t;

    typedef struct packed {
        logic [ERR_W-1:0]   errors;
        logic [PHASE_W-1:0] phase_next;
    } pberc_cmp_rsp_t;

    // Count set bits in one byte
    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            n = n + 4'(b[k]);
        end
        return n;
    endfunction

endpackage

/* design/packet_bit_error_rate_checker.sv */
// Packet bit error rate checker, top level.
// Input register, then result register, with a single compare and total update pass.
// Throughput: one transaction per cycle unless out_stall holds the result register.
// Reset: rst_n clears the totals, phase, sequence number, seed and both valid flags.
// A clear transaction zeroes the totals and reports them as zero.
module packet_bit_error_rate_checker #(
    parameter int unsigned COUNTER_BITS = 48
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pberc_pkg::pberc_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pberc_pkg::pberc_out_t  out_data,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_data
);
    import pberc_pkg::*;

    localparam int unsigned SUM_W = COUNTER_BITS + 1;
    localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;

    logic                    in_valid_reg;
    pberc_in_t               in_data_reg;
    logic                    out_valid_reg;
    pberc_out_t              out_data_reg;
    logic [SEED_W-1:0]       seed_reg;
    logic [PHASE_W-1:0]      phase_reg;
    logic [PHASE_W-1:0]      phase_next;
    logic [WORD_W-1:0]       seq_reg;
    logic [WORD_W-1:0]       seq_next;
    logic [COUNTER_BITS-1:0] wrong_reg;
    logic [COUNTER_BITS-1:0] wrong_next;
    logic [COUNTER_BITS-1:0] right_reg;
    logic [COUNTER_BITS-1:0] right_next;
    pberc_out_t              result_next;

    logic                    advance;
    pberc_cmp_req_t          cmp_req;
    pberc_cmp_rsp_t          cmp_rsp;
    logic [SUM_W-1:0]        wrong_sum;
    logic [SUM_W-1:0]        right_sum;
    logic [63:0]             wrong_ext;
    logic [63:0]             right_ext;

    // Move a transaction into the result register when it is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Compare the held word
    assign cmp_req.rx_word  = in_data_reg.rx_word;
    assign cmp_req.seq_word = seq_reg;
    assign cmp_req.seed     = seed_reg;
    assign cmp_req.phase    = phase_reg;

    pberc_compare u_compare (
        .req (cmp_req),
        .rsp (cmp_rsp)
    );

    // Saturating sums of the totals
    assign wrong_sum = {1'b0, wrong_reg} + SUM_W'(cmp_rsp.errors);
    assign right_sum = {1'b0, right_reg} + SUM_W'(WORD_BITS - cmp_rsp.errors);

    // Work out the next state and the result of the held transaction
    always_comb
    begin
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        wrong_next  = wrong_reg;
        right_next  = right_reg;
        result_next.word_bit_errors = '0;
        result_next.sequence_break  = 1'b0;
        if (in_data_reg.action)
        begin
            wrong_next = '0;
            right_next = '0;
        end
        else if (in_data_reg.first_word)
        begin
            result_next.sequence_break = (in_data_reg.rx_word != seq_reg + 32'd1);
            seq_next   = in_data_reg.rx_word;
            phase_next = PHASE_AFTER_SEQ;
        end
        else
        begin
            result_next.word_bit_errors = cmp_rsp.errors;
            wrong_next = wrong_sum[COUNTER_BITS] ? COUNT_MAX : wrong_sum[COUNTER_BITS-1:0];
            right_next = right_sum[COUNTER_BITS] ? COUNT_MAX : right_sum[COUNTER_BITS-1:0];
            phase_next = cmp_rsp.phase_next;
        end
        wrong_ext = 64'(wrong_next);
        right_ext = 64'(right_next);
        result_next.wrong_bits_total = wrong_ext[TOTAL_W-1:0];
        result_next.right_bits_total = right_ext[TOTAL_W-1:0];
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
            phase_reg     <= '0;
            seq_reg       <= '0;
            wrong_reg     <= '0;
            right_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                seq_reg       <= seq_next;
                wrong_reg     <= wrong_next;
                right_reg     <= right_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                seed_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PATTERN_LAST)
        else $error("phase out of range");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.action |=>
            out_data_reg.wrong_bits_total == '0 && out_data_reg.right_bits_total == '0)
        else $error("clear did not zero totals");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.word_bit_errors <= WORD_BITS)
        else $error("bit error count above word width");

    a_break_only_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.sequence_break |-> out_data_reg.word_bit_errors == '0)
        else $error("sequence break on a data word");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("stall with empty input register");

    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(wrong_reg) && $stable(right_reg))
        else $error("totals changed without a transaction");
`endif

endmodule

/* design/pberc_compare.sv */
// Compare unit of the packet bit error rate checker.
// Builds the expected word for the current phase and counts differing bits.
// Depends on pberc_pkg.
module pberc_compare (
    input  pberc_pkg::pberc_cmp_req_t req,
    output pberc_pkg::pberc_cmp_rsp_t rsp
);
    import pberc_pkg::*;

    logic             seq_slot;
    logic [WORD_W-1:0] pattern_word;
    logic [WORD_W-1:0] expect_word;
    logic [WORD_W-1:0] diff;

    // Pick the sequence number on every twentieth phase, else the pattern
    assign seq_slot = (req.phase == '0) || (req.phase == SEQ_SLOT_1) ||
                      (req.phase == SEQ_SLOT_2) || (req.phase == SEQ_SLOT_3);
    assign pattern_word = (WORD_W'(req.seed) << SEED_SHIFT)
                        + (WORD_W'(req.phase) * PATTERN_STEP);
    assign expect_word  = seq_slot ? req.seq_word : pattern_word;
    assign diff         = expect_word ^ req.rx_word;

    // Count differing bits byte by byte
    assign rsp.errors = ERR_W'(byte_ones(diff[7:0]))
                      + ERR_W'(byte_ones(diff[15:8]))
                      + ERR_W'(byte_ones(diff[23:16]))
                      + ERR_W'(byte_ones(diff[31:24]));

    // Advance the phase, wrapping after the last pattern slot
    assign rsp.phase_next = (req.phase == PATTERN_LAST) ? '0 : req.phase + 7'd1;

endmodule
